// ===== design/trie_pkg.sv =====
// shared types and constants of the trie insert/lookup engine
`default_nettype none

package trie_pkg;

    // default node count of the trie
    localparam int unsigned NODES_DEF = 256;

    // configuration register
    localparam int unsigned NODE_LIMIT_W   = 9;
    localparam logic [NODE_LIMIT_W-1:0] NODE_LIMIT_RST = 9'd256;
    localparam int unsigned PADDR_W        = 3;
    // register index, taken from paddr[2] (word aligned)
    localparam logic REG_NODE_LIMIT = 1'b0;

    // item modes, carried on tuser of the input channel
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // output tuser bit positions
    localparam int unsigned OUT_FOUND_BIT   = 0;
    localparam int unsigned OUT_DROPPED_BIT = 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

// ===== design/trie_insert_lookup_engine_unit.sv =====
// top level of the trie insert/lookup engine: edge memory and sequencer
// usage:
//   input stream: one word byte per transfer, tdata = symbol, tuser = mode
//   (0 insert, 1 lookup), tlast marks the final byte of the word.
//   output stream: one result per input transfer, tdata = node reached,
//   tuser[0] = found (last lookup byte), tuser[1] = dropped (trie full).
//   apb port: register node_limit at byte address 0, written and read back.
// item sequence:
//   an item first gets the synchronous read of the edge memory at
//   {cursor, symbol}, then the update and write-back of the entry, in which
//   the result is registered; only then is the next item taken.
//   every entry holds {final mark, target node}, so one read answers both.
// reset:
//   after reset a clearing pass zeroes the edge memory, one entry a cycle,
//   NODES*256 entries (65536 at the default); tready stays low until it ends.
//   apb writes are taken during the pass.
// stall:
//   a new item is taken while the last result still waits in the output
//   register; the item then holds in its update cycle until that result is
//   transferred, and no further input is taken meanwhile.
`default_nettype none

module trie_insert_lookup_engine_unit
    import trie_pkg::*;
#(
    parameter int unsigned NODES = NODES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input stream
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [7:0]          i_s_axis_tdata,   // [7:0] symbol
    input  wire logic                i_s_axis_tuser,   // [0] mode
    input  wire logic                i_s_axis_tlast,   // last
    // output stream
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [7:0]               o_m_axis_tdata,   // [7:0] node
    output logic [1:0]               o_m_axis_tuser,   // [0] found, [1] dropped
    // apb configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int unsigned NW         = $clog2(NODES);
    localparam int unsigned FW         = $clog2(NODES + 1);
    localparam int unsigned AW         = NW + 8;
    localparam int unsigned EDGE_DEPTH = NODES * 256;
    localparam int unsigned CW         = (FW > NODE_LIMIT_W) ? FW : NODE_LIMIT_W;

    // control registers
    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic [NW-1:0]           r_cursor, n_cursor;
    logic [FW-1:0]           r_free, n_free;
    logic                    r_missed, n_missed;
    logic [NODE_LIMIT_W-1:0] r_node_limit, n_node_limit;
    logic                    r_out_valid, n_out_valid;

    // payload registers
    logic                    r_mode;
    logic [7:0]              r_symbol;
    logic                    r_last;
    logic [7:0]              r_out_node, n_out_node;
    logic                    r_out_found, n_out_found;
    logic                    r_out_dropped, n_out_dropped;

    // edge memory: entry = {final mark of target, target node}
    logic [NW:0]             r_edge_mem [EDGE_DEPTH];
    logic [NW:0]             r_rdata;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [NW:0]             mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;

    logic                    in_fire;
    logic                    cfg_wr;
    logic                    out_free;
    logic                    exec_fire;
    logic [NW-1:0]           ent_target;
    logic                    ent_final;
    logic [CW-1:0]           free_ext;
    logic [CW-1:0]           limit_ext;
    logic                    full;
    logic                    hit;
    logic [NW-1:0]           nxt;
    logic [NW-1:0]           res_node;
    logic [NW+7:0]           res_node_ext;

    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_NODE_LIMIT);
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign exec_fire = (r_state == ST_EXEC) && out_free;

    assign ent_target = r_rdata[NW-1:0];
    assign ent_final  = r_rdata[NW];
    assign free_ext   = CW'(r_free);
    assign limit_ext  = CW'(r_node_limit);
    assign full       = (free_ext >= limit_ext) || (free_ext >= CW'(NODES));
    assign hit        = (ent_target != '0);
    assign nxt        = hit ? ent_target : r_free[NW-1:0];

    assign mem_re    = in_fire;
    assign mem_raddr = {r_cursor, i_s_axis_tdata};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_edge_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_edge_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_cursor     <= '0;
            r_free       <= FW'(1);
            r_missed     <= 1'b0;
            r_node_limit <= NODE_LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_cursor     <= n_cursor;
            r_free       <= n_free;
            r_missed     <= n_missed;
            r_node_limit <= n_node_limit;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode   <= i_s_axis_tuser;
            r_symbol <= i_s_axis_tdata;
            r_last   <= i_s_axis_tlast;
        end
        r_out_node    <= n_out_node;
        r_out_found   <= n_out_found;
        r_out_dropped <= n_out_dropped;
    end

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_cursor      = r_cursor;
        n_free        = r_free;
        n_missed      = r_missed;
        n_node_limit  = r_node_limit;
        n_out_valid   = r_out_valid;
        n_out_node    = r_out_node;
        n_out_found   = r_out_found;
        n_out_dropped = r_out_dropped;
        o_s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {r_cursor, r_symbol};
        mem_wdata     = '0;
        res_node      = r_cursor;

        if (cfg_wr) begin
            n_node_limit = pwdata[NODE_LIMIT_W-1:0];
        end
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(EDGE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    n_state       = ST_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_found   = 1'b0;
                    n_out_dropped = 1'b0;
                    if (r_mode == MODE_INSERT) begin
                        if (full) begin
                            n_out_dropped = 1'b1;
                            res_node      = r_cursor;
                        end else begin
                            // new edge, or final mark set on an existing edge
                            mem_we    = !hit || r_last;
                            mem_wdata = {r_last || (hit && ent_final), nxt};
                            if (!hit) begin
                                n_free = r_free + FW'(1);
                            end
                            n_cursor = nxt;
                            res_node = nxt;
                        end
                    end else begin
                        if (r_missed || !hit) begin
                            n_missed = 1'b1;
                            n_cursor = '0;
                            res_node = '0;
                        end else begin
                            n_cursor    = ent_target;
                            res_node    = ent_target;
                            n_out_found = r_last && ent_final;
                        end
                    end
                    if (r_last) begin
                        n_cursor = '0;
                        n_missed = 1'b0;
                    end
                    n_out_node = res_node_ext[7:0];
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign res_node_ext = {8'b0, res_node};

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_node;
    always_comb begin
        o_m_axis_tuser                  = '0;
        o_m_axis_tuser[OUT_FOUND_BIT]   = r_out_found;
        o_m_axis_tuser[OUT_DROPPED_BIT] = r_out_dropped;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_LIMIT) ? 32'(r_node_limit) : 32'b0;

endmodule

`default_nettype wire

// ===== design/trie_chk.sv =====
// port-level checker for the trie insert/lookup engine, bound to the top level
`default_nettype none

module trie_chk
    import trie_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [7:0]  o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output payload changed while stalled");

    // a result is never both found and dropped
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[OUT_FOUND_BIT] && o_m_axis_tuser[OUT_DROPPED_BIT]))
        else $error("found and dropped both set");

    // clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_axis_tready)
        else $error("input taken before memory clear");

    // tready is low right after each input transfer
    a_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken in back-to-back cycles");

endmodule

bind trie_insert_lookup_engine_unit trie_chk u_trie_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
